@@ hdl/lochk_pkg.sv @@
`default_nettype none
package lochk_pkg;

	localparam int MAX_HELD = 16;
	localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int DEPTH_W  = $clog2(MAX_HELD + 1);

	localparam int ID_W     = 16;
	localparam int RANK_W   = 8;
	localparam int STATUS_W = 3;
	localparam int HDEPTH_W = 5;
	localparam int TIDX_W   = 4;

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_CHECK_ENABLE = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ORDER     = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_RELORDER  = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

@@ hdl/lock_order_checker_top.sv @@
// Lock-order checker for one CPU.
// Request channel (req_valid/req_ready): cmd 0 acquires, 1 releases;
// lock_id, lock_rank and is_pivot describe the lock. A request is taken
// when req_valid and req_ready are both high at a rising edge of clk.
// Result channel (rsp_valid/rsp_ready): status, held_depth, top_rank_seen,
// target_found and target_index, one result for every request.
// Flow: the controller registers the request, then executes it, comparing
// it against all held entries in parallel and updating the stack;
// rsp_valid rises when the request executes. No new request is taken
// until the current one has executed.
// A result waits in its output register while the receiver stalls; the
// next request is still taken, and its update is held until the waiting
// result is taken.
// APB port: register check_enable at byte address 0, reset 0. While it is
// zero every request returns ok and the stack is left alone. Write it only
// while no request is in flight.
// Reset (arst_n low) empties the stack and clears check_enable.
`default_nettype none
module lock_order_checker_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// request channel
	input  wire                                  req_valid,
	output logic                                 req_ready,
	input  wire                                  cmd,
	input  wire  [lochk_pkg::ID_W-1:0]           lock_id,
	input  wire  [lochk_pkg::RANK_W-1:0]         lock_rank,
	input  wire                                  is_pivot,
	// result channel
	output logic                                 rsp_valid,
	input  wire                                  rsp_ready,
	output logic [lochk_pkg::STATUS_W-1:0]       status,
	output logic [lochk_pkg::HDEPTH_W-1:0]       held_depth,
	output logic [lochk_pkg::RANK_W-1:0]         top_rank_seen,
	output logic                                 target_found,
	output logic [lochk_pkg::TIDX_W-1:0]         target_index,
	// configuration port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [lochk_pkg::PADDR_W-1:0]        paddr,
	input  wire  [lochk_pkg::PDATA_W-1:0]        pwdata,
	output logic [lochk_pkg::PDATA_W-1:0]        prdata,
	output logic                                 pready
);

	lochk_pkg::ctrl_cmd_t ctrl;
	logic                 check_enable_q;
	logic                 reg_sel;

	// register index sits in paddr[2]; anything past it reads as zero
	assign reg_sel = (paddr[2] == lochk_pkg::REG_CHECK_ENABLE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			check_enable_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = check_enable_q;
		end
	end

	// sequence each request: register it, then execute it
	lochk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctrl      (ctrl)
	);

	// hold the lock stack, check and update it, drive the result
	lochk_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.check_enable  (check_enable_q),
		.cmd           (cmd),
		.lock_id       (lock_id),
		.lock_rank     (lock_rank),
		.is_pivot      (is_pivot),
		.status        (status),
		.held_depth    (held_depth),
		.top_rank_seen (top_rank_seen),
		.target_found  (target_found),
		.target_index  (target_index)
	);

endmodule
`default_nettype wire

@@ hdl/lochk_ctrl.sv @@
`default_nettype none
module lochk_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output lochk_pkg::ctrl_cmd_t ctrl
);

	lochk_pkg::fsm_state_t state_q, state_d;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lochk_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ctrl      = '0;
		case (state_q)
			lochk_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.load = 1'b1;
					state_d   = lochk_pkg::S_EXEC;
				end
			end
			lochk_pkg::S_EXEC: begin
				// hold while the previous result still waits
				if (!rsp_valid_q || rsp_ready) begin
					ctrl.exec = 1'b1;
					state_d   = lochk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lochk_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

@@ hdl/lochk_dp.sv @@
`default_nettype none
module lochk_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  lochk_pkg::ctrl_cmd_t                   ctrl,
	input  wire                                    check_enable,
	input  wire                                    cmd,
	input  wire  [lochk_pkg::ID_W-1:0]             lock_id,
	input  wire  [lochk_pkg::RANK_W-1:0]           lock_rank,
	input  wire                                    is_pivot,
	output logic [lochk_pkg::STATUS_W-1:0]         status,
	output logic [lochk_pkg::HDEPTH_W-1:0]         held_depth,
	output logic [lochk_pkg::RANK_W-1:0]           top_rank_seen,
	output logic                                   target_found,
	output logic [lochk_pkg::TIDX_W-1:0]           target_index
);

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_HANDOFF
	} stack_op_t;

	// slot 0 is the top of the stack; slot k holds stack position depth-1-k
	logic [lochk_pkg::ID_W-1:0]    id_q   [lochk_pkg::MAX_HELD];
	logic [lochk_pkg::RANK_W-1:0]  rank_q [lochk_pkg::MAX_HELD];
	logic                          piv_q  [lochk_pkg::MAX_HELD];
	logic [lochk_pkg::DEPTH_W-1:0] depth_q;

	lochk_pkg::cmd_t               cmd_q;
	logic [lochk_pkg::ID_W-1:0]    id_in_q;
	logic [lochk_pkg::RANK_W-1:0]  rank_in_q;
	logic                          piv_in_q;

	logic                          has_top, has_two, full;
	logic                          viol, match_top, handoff;
	logic [lochk_pkg::MAX_HELD-1:0] hit;
	logic                          found;
	logic [lochk_pkg::IDX_W-1:0]   slot;
	logic [lochk_pkg::DEPTH_W-1:0] where_full;
	logic [lochk_pkg::RANK_W-1:0]  head_rank;
	lochk_pkg::status_t            status_d;
	stack_op_t                     op;
	logic [lochk_pkg::DEPTH_W-1:0] depth_d;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= lochk_pkg::cmd_t'(cmd);
			id_in_q   <= lock_id;
			rank_in_q <= lock_rank;
			piv_in_q  <= is_pivot;
		end
	end

	assign has_top   = (depth_q != '0);
	assign has_two   = (depth_q >= lochk_pkg::DEPTH_W'(2));
	assign full      = (depth_q >= lochk_pkg::DEPTH_W'(lochk_pkg::MAX_HELD));
	assign head_rank = has_top ? rank_q[0] : '0;

	assign viol      = has_top && !piv_in_q && !piv_q[0] && (rank_in_q < rank_q[0]);
	assign match_top = has_top && (id_q[0] == id_in_q);
	assign handoff   = has_two && piv_q[0] && (id_q[1] == id_in_q);

	always_comb begin
		for (int k = 0; k < lochk_pkg::MAX_HELD; k++) begin
			hit[k] = (lochk_pkg::DEPTH_W'(k) < depth_q) && (id_q[k] == id_in_q);
		end
		// nearest the top wins
		found = 1'b0;
		slot  = '0;
		for (int k = lochk_pkg::MAX_HELD - 1; k >= 0; k--) begin
			if (hit[k]) begin
				found = 1'b1;
				slot  = lochk_pkg::IDX_W'(k);
			end
		end
	end

	assign where_full = depth_q - lochk_pkg::DEPTH_W'(1) - lochk_pkg::DEPTH_W'(slot);

	always_comb begin
		status_d = lochk_pkg::ST_OK;
		op       = OP_NONE;
		if (check_enable) begin
			case (cmd_q)
				lochk_pkg::CMD_ACQUIRE: begin
					if (viol) begin
						status_d = lochk_pkg::ST_ORDER;
					end else if (full) begin
						status_d = lochk_pkg::ST_OVERFLOW;
					end else begin
						op = OP_PUSH;
					end
				end
				lochk_pkg::CMD_RELEASE: begin
					if (!has_top) begin
						status_d = lochk_pkg::ST_UNDERFLOW;
					end else if (match_top) begin
						op = OP_POP;
					end else if (handoff) begin
						op = OP_HANDOFF;
					end else begin
						status_d = lochk_pkg::ST_RELORDER;
					end
				end
				default: begin
					status_d = lochk_pkg::ST_OK;
				end
			endcase
		end
	end

	always_comb begin
		case (op)
			OP_PUSH:              depth_d = depth_q + lochk_pkg::DEPTH_W'(1);
			OP_POP, OP_HANDOFF:   depth_d = depth_q - lochk_pkg::DEPTH_W'(1);
			default:              depth_d = depth_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctrl.exec) begin
			depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			case (op)
				OP_PUSH: begin
					id_q[0]   <= id_in_q;
					rank_q[0] <= rank_in_q;
					piv_q[0]  <= piv_in_q;
					for (int k = 1; k < lochk_pkg::MAX_HELD; k++) begin
						id_q[k]   <= id_q[k-1];
						rank_q[k] <= rank_q[k-1];
						piv_q[k]  <= piv_q[k-1];
					end
				end
				OP_POP: begin
					for (int k = 0; k < lochk_pkg::MAX_HELD - 1; k++) begin
						id_q[k]   <= id_q[k+1];
						rank_q[k] <= rank_q[k+1];
						piv_q[k]  <= piv_q[k+1];
					end
					id_q[lochk_pkg::MAX_HELD-1]   <= '0;
					rank_q[lochk_pkg::MAX_HELD-1] <= '0;
					piv_q[lochk_pkg::MAX_HELD-1]  <= 1'b0;
				end
				OP_HANDOFF: begin
					// keep the pivot on top, close the gap below it
					for (int k = 1; k < lochk_pkg::MAX_HELD - 1; k++) begin
						id_q[k]   <= id_q[k+1];
						rank_q[k] <= rank_q[k+1];
						piv_q[k]  <= piv_q[k+1];
					end
					id_q[lochk_pkg::MAX_HELD-1]   <= '0;
					rank_q[lochk_pkg::MAX_HELD-1] <= '0;
					piv_q[lochk_pkg::MAX_HELD-1]  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			status        <= status_d;
			held_depth    <= lochk_pkg::HDEPTH_W'(depth_d);
			top_rank_seen <= head_rank;
			if (status_d == lochk_pkg::ST_RELORDER && found) begin
				target_found <= 1'b1;
				target_index <= lochk_pkg::TIDX_W'(where_full[lochk_pkg::IDX_W-1:0]);
			end else begin
				target_found <= 1'b0;
				target_index <= '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/lochk_checker.sv @@
`default_nettype none
module lochk_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 req_valid,
	input wire                                 req_ready,
	input wire                                 rsp_valid,
	input wire                                 rsp_ready,
	input wire [lochk_pkg::STATUS_W-1:0]       status,
	input wire [lochk_pkg::HDEPTH_W-1:0]       held_depth,
	input wire                                 target_found
);

	// after a request is taken, req_ready is low in the cycle after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while one is in flight");

	// a fresh result rises once its request has passed through the EXEC state
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without a matching request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == lochk_pkg::ST_OK || status == lochk_pkg::ST_ORDER ||
			status == lochk_pkg::ST_OVERFLOW || status == lochk_pkg::ST_UNDERFLOW ||
			status == lochk_pkg::ST_RELORDER))
		else $error("unknown status code");

	a_found_only_on_relorder: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && target_found) |-> (status == lochk_pkg::ST_RELORDER))
		else $error("target reported outside a release order error");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(held_depth)))
		else $error("stalled result changed");

endmodule

bind lock_order_checker_top lochk_checker u_lochk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_ready    (req_ready),
	.rsp_valid    (rsp_valid),
	.rsp_ready    (rsp_ready),
	.status       (status),
	.held_depth   (held_depth),
	.target_found (target_found)
);
`default_nettype wire
